// File: src/ort_pkg.sv
// Shared types and constants for the ordered route table.
// Entry layout, operation and status codes, and the cell control bundle.
// No dependencies.
package ort_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = 24;
    localparam int TTL_W    = 8;
    localparam int USED_W   = 5;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [TTL_W-1:0]  ttl;
    } entry_t;

    typedef struct packed {
        logic              accept;
        logic [1:0]        op;
        logic [ADDR_W-1:0] key;
        entry_t            wr_entry;
    } cell_ctrl_t;

endpackage

// File: src/ort_cell.sv
// One slot of the route table chain: holds an entry, compares its key,
// and takes its upper neighbor's entry when a delete compacts the chain.
// Depends on ort_pkg.
module ort_cell (
    input  logic                aclk,
    input  ort_pkg::cell_ctrl_t ctrl,
    input  logic                active,
    input  logic                is_tail,
    input  logic                match_in,
    input  ort_pkg::entry_t     entry_nbr,
    output logic                match_out,
    output logic                first_hit,
    output ort_pkg::entry_t     entry_q
);

    ort_pkg::entry_t entry_reg;
    ort_pkg::entry_t entry_next;
    logic            hit;

    always_comb begin
        hit        = active && (entry_reg.dst == ctrl.key);
        match_out  = match_in || hit;
        first_hit  = hit && !match_in;
        entry_next = entry_reg;
        if (ctrl.accept) begin
            unique case (ctrl.op)
                ort_pkg::OP_APPEND: begin
                    if (is_tail) begin
                        entry_next = ctrl.wr_entry;
                    end
                end
                ort_pkg::OP_DELETE: begin
                    if (match_out) begin
                        entry_next = entry_nbr;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule

// File: src/ordered_route_table.sv
// Ordered route table top level: chain of ort_cell slots plus fill count
// and a registered result stage. Depends on ort_pkg and ort_cell.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one operation per cycle while the result side takes transfers;
// set by the compare, first-match ripple and shift in the chain.
// Reset (aresetn low, synchronous): table empty, no result pending.
module ordered_route_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // op[1:0], src_addr[25:2], dst_addr[49:26], hop_limit[57:50]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // status[1:0], found_src[25:2], found_hops[33:26],
                                  // used_count[38:34]
);

    localparam int CAP   = ort_pkg::CAPACITY;
    localparam int CW    = ort_pkg::CNT_W;
    localparam int AW    = ort_pkg::ADDR_W;
    localparam int TW    = ort_pkg::TTL_W;
    localparam int UW    = ort_pkg::USED_W;
    localparam int OUT_W = 2 + AW + TW + UW;

    logic                s_fire;
    logic [1:0]          in_op;
    ort_pkg::cell_ctrl_t ctrl;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic [OUT_W-1:0]    m_tdata_next;

    logic [CAP:0]        match_chain;
    logic [CAP-1:0]      first_vec;
    ort_pkg::entry_t     entry_q [CAP];

    logic                any_match;
    logic [AW-1:0]       sel_src;
    logic [TW-1:0]       sel_ttl;
    logic [1:0]          status;
    logic [AW-1:0]       res_src;
    logic [TW-1:0]       res_ttl;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign in_op    = s_tdata[1:0];

    assign ctrl.accept       = s_fire;
    assign ctrl.op           = in_op;
    assign ctrl.key          = s_tdata[49:26];
    assign ctrl.wr_entry.src = s_tdata[25:2];
    assign ctrl.wr_entry.dst = s_tdata[49:26];
    assign ctrl.wr_entry.ttl = s_tdata[57:50];

    assign match_chain[0] = 1'b0;

    for (genvar i = 0; i < CAP; i++) begin : g_cell
        ort_pkg::entry_t nbr;
        if (i < CAP - 1) begin : g_mid
            assign nbr = entry_q[i+1];
        end else begin : g_end
            assign nbr = entry_q[i];
        end
        ort_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .active    (CW'(i) < count_reg),
            .is_tail   (CW'(i) == count_reg),
            .match_in  (match_chain[i]),
            .entry_nbr (nbr),
            .match_out (match_chain[i+1]),
            .first_hit (first_vec[i]),
            .entry_q   (entry_q[i])
        );
    end

    assign any_match = match_chain[CAP];

    always_comb begin
        sel_src = '0;
        sel_ttl = '0;
        for (int i = 0; i < CAP; i++) begin
            sel_src = sel_src | (entry_q[i].src & {AW{first_vec[i]}});
            sel_ttl = sel_ttl | (entry_q[i].ttl & {TW{first_vec[i]}});
        end
    end

    always_comb begin
        count_next = count_reg;
        status     = ort_pkg::ST_OK;
        res_src    = '0;
        res_ttl    = '0;
        unique case (in_op)
            ort_pkg::OP_APPEND: begin
                if (count_reg == CW'(CAP)) begin
                    status = ort_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
            ort_pkg::OP_LOOKUP: begin
                if (any_match) begin
                    res_src = sel_src;
                    res_ttl = sel_ttl;
                end else begin
                    status = ort_pkg::ST_NOTFOUND;
                end
            end
            ort_pkg::OP_DELETE: begin
                if (any_match) begin
                    count_next = count_reg - CW'(1);
                end else begin
                    status = ort_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                count_next = '0;
            end
        endcase
        m_tdata_next = {UW'(count_next), res_ttl, res_src, status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(40 - OUT_W){1'b0}}, m_tdata_reg};

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAP))
        else $error("fill count above capacity");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (in_op == ort_pkg::OP_CLEAR) |=> count_reg == '0)
        else $error("clear did not empty the table");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (status == ort_pkg::ST_FULL) |-> count_reg == CW'(CAP))
        else $error("full reported on a table with room");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(first_vec))
        else $error("more than one first-match cell");

    a_hit_agrees: assert property (@(posedge aclk) disable iff (!aresetn)
        any_match == (first_vec != '0))
        else $error("match chain and first-match vector disagree");

endmodule
